// ----- rtl/core/lse_pkg.sv -----
// Shared types and constants for the LSB stego extractor core.
// No dependencies; used by every module in rtl/core.
`default_nettype none

package lse_pkg;

  // Framing limits
  localparam int unsigned MAX_EXT_LEN = 16;  // extension bytes incl. the terminator, 2..256
  localparam int unsigned SIZE_BYTES  = 4;   // big-endian size header bytes, 1..4

  localparam int unsigned FLAG_BYTES  = 4;   // LSBI inversion flag bytes

  // embed_mode codes; code 3 behaves as LSB1
  localparam logic [1:0] MODE_LSB1 = 2'd0;
  localparam logic [1:0] MODE_LSB4 = 2'd1;
  localparam logic [1:0] MODE_LSBI = 2'd2;

  localparam logic [7:0] CHAR_DOT = 8'h2E;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_LEN = 2'd1,
    ST_NO_DOT   = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  // one result word
  typedef struct packed {
    logic [31:0] payload_size;
    status_e     status;
    logic        last_of_part;
    logic        is_extension;
    logic [7:0]  out_byte;
  } res_t;

  // bit gatherer state and outcome
  typedef struct packed {
    logic [7:0] acc;
    logic [3:0] bits;
    logic       done;
  } gather_t;

endpackage

`default_nettype wire

// ----- rtl/core/lsb_stego_extractor_core.sv -----
// Top level of the LSB stego extractor: input stage, mode register, deframer.
// Depends on lse_pkg, lse_bit_gather and lse_deframer.
//
//  channel   | direction | tdata / data                      | tuser                  | tlast
//  ----------+-----------+-----------------------------------+------------------------+-------
//  s_axis    | in        | [7:0] cover_byte                  | [0] start_frame        | -
//  m_axis    | out       | [7:0] out_byte, [39:8] payload_sz | [0] is_ext, [2:1] stat | last
//  cfg       | in        | [1:0] embed_mode                  | -                      | -
//
// One cover word per cycle sustained while m_axis takes results. A word is staged in the input register,
// then processed by the deframer into the result register that drives m_axis. The frame update is a
// single pass of short logic (8-bit shift, 32-bit increment and compare). Reset clears mode,
// frame state and both valid flags. A stalled m_axis holds the result; s_axis keeps taking a
// word while the staged word can still move on.
`default_nettype none

module lsb_stego_extractor_core #(
  parameter int unsigned MAX_EXT_LEN = lse_pkg::MAX_EXT_LEN,  // extension bytes incl. NUL
  parameter int unsigned SIZE_BYTES  = lse_pkg::SIZE_BYTES    // size header bytes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // cover stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] cover_byte
  input  wire logic [0:0]  s_axis_tuser,   // [0] start_frame
  // recovered stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [7:0] out_byte, [39:8] payload_size
  output logic [2:0]       m_axis_tuser,   // [0] is_extension, [2:1] status
  output logic             m_axis_tlast,   // last_of_part
  // mode register write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_data_i      // [1:0] embed_mode
);

  logic [1:0]    embed_mode_q, embed_mode_d;
  logic          in_valid_q, in_valid_d;
  logic [7:0]    in_cover_q;
  logic          in_start_q;
  logic          advance;      // result register free for the staged word
  logic          s_fire;
  logic          res_valid;
  lse_pkg::res_t res;

  // mode register, always writable
  assign cfg_ready_o  = 1'b1;
  assign embed_mode_d = cfg_valid_i ? cfg_data_i : embed_mode_q;

  // input stage
  assign advance       = ~res_valid | m_axis_tready;
  assign s_axis_tready = ~in_valid_q | advance;
  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign in_valid_d    = s_fire | (in_valid_q & ~advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      embed_mode_q <= lse_pkg::MODE_LSB1;
      in_valid_q   <= 1'b0;
    end else begin
      embed_mode_q <= embed_mode_d;
      in_valid_q   <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_cover_q <= s_axis_tdata;
      in_start_q <= s_axis_tuser[0];
    end
  end

  lse_deframer #(
    .MAX_EXT_LEN (MAX_EXT_LEN),
    .SIZE_BYTES  (SIZE_BYTES)
  ) u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (embed_mode_q),
    .step_i      (in_valid_q & advance),
    .cover_i     (in_cover_q),
    .start_i     (in_start_q),
    .pop_i       (m_axis_tready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {res.payload_size, res.out_byte};
  assign m_axis_tuser  = {res.status, res.is_extension};
  assign m_axis_tlast  = res.last_of_part;

endmodule

`default_nettype wire

// ----- rtl/core/lse_bit_gather.sv -----
// Hidden-bit gatherer: shifts LSB/nibble bits of one cover byte into the accumulator.
// Depends on lse_pkg.
`default_nettype none

module lse_bit_gather (
  input  wire logic [1:0]       mode_i,
  input  wire logic [3:0]       flags_i,
  input  wire logic [7:0]       acc_i,
  input  wire logic [3:0]       bits_i,
  input  wire logic [7:0]       cover_i,
  output lse_pkg::gather_t      gather_o
);

  logic       hid_bit;
  logic [3:0] bits_sum;

  always_comb begin
    hid_bit  = cover_i[0];
    bits_sum = bits_i;
    gather_o = '0;
    if (mode_i == lse_pkg::MODE_LSB4) begin
      gather_o.acc = {acc_i[3:0], cover_i[3:0]};
      bits_sum     = bits_i + 4'd4;
    end else begin
      // LSBI flips the bit by the flag picked by cover bits 2..1
      if (mode_i == lse_pkg::MODE_LSBI) begin
        hid_bit = cover_i[0] ^ flags_i[cover_i[2:1]];
      end
      gather_o.acc = {acc_i[6:0], hid_bit};
      bits_sum     = bits_i + 4'd1;
    end
    gather_o.bits = bits_sum;
    gather_o.done = (bits_sum >= 4'd8);
  end

endmodule

`default_nettype wire

// ----- rtl/core/lse_deframer.sv -----
// Frame state machine: flags, size header, payload, extension; holds the result register.
// Depends on lse_pkg and lse_bit_gather.
`default_nettype none

module lse_deframer #(
  parameter int unsigned MAX_EXT_LEN = lse_pkg::MAX_EXT_LEN,
  parameter int unsigned SIZE_BYTES  = lse_pkg::SIZE_BYTES
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [1:0]    mode_i,
  input  wire logic          step_i,    // process the staged word this cycle
  input  wire logic [7:0]    cover_i,
  input  wire logic          start_i,
  input  wire logic          pop_i,     // result taken downstream
  output logic               res_valid_o,
  output lse_pkg::res_t      res_o
);

  typedef enum logic [2:0] {
    PH_FLAGS   = 3'd0,
    PH_SIZE    = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_EXT     = 3'd3,
    PH_IDLE    = 3'd4
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [3:0]    flags_q, flags_d;
  logic [7:0]    acc_q, acc_d;
  logic [3:0]    bits_q, bits_d;
  logic [31:0]   size_q, size_d;
  logic [31:0]   cnt_q, cnt_d;
  logic          res_valid_q, res_valid_d;
  lse_pkg::res_t res_q, res_d;

  // frame state as seen by this word (after an optional restart)
  phase_e        ph_e;
  logic [3:0]    flags_e, acc_bits_e;
  logic [7:0]    acc_e;
  logic [31:0]   size_e, cnt_e, cnt_inc;
  logic [7:0]    hb;
  logic          run;
  lse_pkg::gather_t gth;

  always_comb begin
    if (start_i) begin
      ph_e       = PH_FLAGS;
      flags_e    = '0;
      acc_e      = '0;
      acc_bits_e = '0;
      size_e     = '0;
      cnt_e      = '0;
    end else begin
      ph_e       = phase_q;
      flags_e    = flags_q;
      acc_e      = acc_q;
      acc_bits_e = bits_q;
      size_e     = size_q;
      cnt_e      = cnt_q;
    end
  end

  lse_bit_gather u_gather (
    .mode_i   (mode_i),
    .flags_i  (flags_e),
    .acc_i    (acc_e),
    .bits_i   (acc_bits_e),
    .cover_i  (cover_i),
    .gather_o (gth)
  );

  always_comb begin
    phase_d     = phase_q;
    flags_d     = flags_q;
    acc_d       = acc_q;
    bits_d      = bits_q;
    size_d      = size_q;
    cnt_d       = cnt_q;
    res_valid_d = res_valid_q & ~pop_i;
    res_d       = res_q;
    hb          = gth.acc;
    cnt_inc     = cnt_e + 32'd1;
    run         = 1'b0;

    if (step_i) begin
      phase_d     = ph_e;
      flags_d     = flags_e;
      acc_d       = acc_e;
      bits_d      = acc_bits_e;
      size_d      = size_e;
      cnt_d       = cnt_e;
      res_valid_d = 1'b0;

      if (ph_e == PH_FLAGS) begin
        if (mode_i == lse_pkg::MODE_LSBI) begin
          if (cover_i[0]) begin
            flags_d[cnt_e[1:0]] = 1'b1;
          end
          if (cnt_inc >= 32'(lse_pkg::FLAG_BYTES)) begin
            cnt_d   = '0;
            phase_d = PH_SIZE;
          end else begin
            cnt_d = cnt_inc;
          end
        end else begin
          // no flag bytes outside LSBI: this byte already feeds the size
          cnt_d   = '0;
          phase_d = PH_SIZE;
          run     = 1'b1;
        end
      end else if (ph_e == PH_SIZE || ph_e == PH_PAYLOAD || ph_e == PH_EXT) begin
        run = 1'b1;
      end

      if (run) begin
        acc_d  = gth.acc;
        bits_d = gth.bits;
        if (gth.done) begin
          acc_d  = '0;
          bits_d = '0;
          if (phase_d == PH_SIZE) begin
            size_d = {size_e[23:0], hb};
            if (cnt_d + 32'd1 < 32'(SIZE_BYTES)) begin
              cnt_d = cnt_d + 32'd1;
            end else begin
              cnt_d = '0;
              if (size_d == '0) begin
                phase_d     = PH_IDLE;
                res_valid_d = 1'b1;
                res_d       = '{payload_size: size_d, status: lse_pkg::ST_ZERO_LEN,
                                last_of_part: 1'b1, is_extension: 1'b0,
                                out_byte: lse_pkg::CHAR_NUL};
              end else begin
                phase_d = PH_PAYLOAD;
              end
            end
          end else if (phase_d == PH_PAYLOAD) begin
            res_valid_d = 1'b1;
            res_d       = '{payload_size: size_e, status: lse_pkg::ST_OK,
                            last_of_part: 1'b0, is_extension: 1'b0, out_byte: hb};
            if (cnt_inc == size_e) begin
              cnt_d              = '0;
              phase_d            = PH_EXT;
              res_d.last_of_part = 1'b1;
            end else begin
              cnt_d = cnt_inc;
            end
          end else begin
            // extension
            res_valid_d = 1'b1;
            res_d       = '{payload_size: size_e, status: lse_pkg::ST_OK,
                            last_of_part: 1'b1, is_extension: 1'b1, out_byte: hb};
            if (cnt_e == '0 && hb != lse_pkg::CHAR_DOT) begin
              phase_d      = PH_IDLE;
              res_d.status = lse_pkg::ST_NO_DOT;
            end else if (hb == lse_pkg::CHAR_NUL) begin
              phase_d = PH_IDLE;
            end else if (cnt_inc >= 32'(MAX_EXT_LEN)) begin
              phase_d      = PH_IDLE;
              res_d.status = lse_pkg::ST_TOO_LONG;
            end else begin
              cnt_d              = cnt_inc;
              res_d.last_of_part = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FLAGS;
      flags_q     <= '0;
      acc_q       <= '0;
      bits_q      <= '0;
      size_q      <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      flags_q     <= flags_d;
      acc_q       <= acc_d;
      bits_q      <= bits_d;
      size_q      <= size_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ----- rtl/core/lse_checker.sv -----
// Port-level checks for lsb_stego_extractor_core, bound to the top level.
// Depends on lse_pkg.
`default_nettype none

module lse_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // any error closes the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2:1] != lse_pkg::ST_OK |-> m_axis_tlast)
    else $error("error result without last");

  // zero size: empty payload word carrying a zero size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2:1] == lse_pkg::ST_ZERO_LEN |->
      m_axis_tdata == '0 && !m_axis_tuser[0])
    else $error("zero-size result malformed");

  // extension errors only on extension words; payload words never carry a size of zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] && m_axis_tuser[2:1] == lse_pkg::ST_OK |->
      m_axis_tdata[39:8] != '0)
    else $error("payload word with zero size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[2:1] == lse_pkg::ST_NO_DOT ||
      m_axis_tuser[2:1] == lse_pkg::ST_TOO_LONG) |-> m_axis_tuser[0])
    else $error("extension error on payload word");

endmodule

bind lsb_stego_extractor_core lse_checker u_lse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking bench for lsb_stego_extractor_core: random cover streams in all modes.
// Needs lse_pkg and the core RTL; a built-in predictor checks every recovered word.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEMS_TARGET  = 1000;
  localparam int unsigned SETTLE_CYCLES = 10;     // pipeline is two deep, leave slack
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned HOLD_AFTER    = 40;     // results seen before the long hold-off

  // frame shapes the generator can build
  localparam int FK_GOOD  = 0;
  localparam int FK_ZERO  = 1;
  localparam int FK_NODOT = 2;
  localparam int FK_LONG  = 3;
  localparam int FK_CUT   = 4;

  typedef enum logic [2:0] {FR_FLAGS, FR_SIZE, FR_BODY, FR_EXT, FR_DONE} frame_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } cover_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  logic        tx_valid  = 1'b0;
  logic [7:0]  tx_data   = '0;
  logic [0:0]  tx_user   = '0;
  logic        rx_ready  = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_data  = '0;

  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_ready_o;

  lsb_stego_extractor_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (tx_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (tx_data),
    .s_axis_tuser  (tx_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (rx_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  cover_t          cover_q[$];      // words waiting for the driver
  cover_t          frame_q[$];      // frame under construction
  lse_pkg::res_t   recovered_q[$];  // predicted output words, oldest first
  int unsigned     fail_count = 0;
  int unsigned     items_sent = 0;

  // mode as last written; only changes while nothing is in flight
  logic [1:0]  mode_reg = lse_pkg::MODE_LSB1;

  // predictor state
  frame_phase_e fr_phase  = FR_FLAGS;
  logic [3:0]   flip_mask = '0;
  logic [7:0]   hid_shift = '0;
  logic [3:0]   hid_bits  = '0;
  logic [31:0]  hdr_size  = '0;
  logic [31:0]  frame_cnt = '0;

  // generator state
  logic         start_pending = 1'b0;
  logic [3:0]   gen_key       = '0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic queue_result(input logic [7:0] b, input logic ext, input logic lst,
                              input lse_pkg::status_e st);
    lse_pkg::res_t r;
    r.out_byte     = b;
    r.is_extension = ext;
    r.last_of_part = lst;
    r.status       = st;
    r.payload_size = hdr_size;
    recovered_q.push_back(r);
  endtask

  // One accepted cover word through the extractor.
  task automatic recover_hidden(input logic [7:0] cb, input logic start);
    logic [7:0] hb;
    logic       bit_v;
    if (start) begin
      flip_mask = '0;
      fr_phase  = FR_FLAGS;
      hid_shift = '0;
      hid_bits  = '0;
      hdr_size  = '0;
      frame_cnt = '0;
    end
    if (fr_phase == FR_FLAGS) begin
      if (mode_reg == lse_pkg::MODE_LSBI) begin
        if (cb[0]) flip_mask[frame_cnt[1:0]] = 1'b1;
        frame_cnt++;
        if (frame_cnt >= lse_pkg::FLAG_BYTES) begin
          frame_cnt = '0;
          fr_phase  = FR_SIZE;
        end
        return;
      end
      // no flag words outside LSBI: this word already carries size bits
      frame_cnt = '0;
      fr_phase  = FR_SIZE;
    end
    if (fr_phase == FR_DONE) return;

    if (mode_reg == lse_pkg::MODE_LSB4) begin
      hid_shift = {hid_shift[3:0], cb[3:0]};
      hid_bits  = hid_bits + 4'd4;
    end else begin
      bit_v = cb[0];
      if (mode_reg == lse_pkg::MODE_LSBI) bit_v = bit_v ^ flip_mask[cb[2:1]];
      hid_shift = {hid_shift[6:0], bit_v};
      hid_bits  = hid_bits + 4'd1;
    end
    // surplus bits past eight are dropped
    if (hid_bits < 4'd8) return;
    hb        = hid_shift;
    hid_bits  = '0;
    hid_shift = '0;

    case (fr_phase)
      FR_SIZE: begin
        hdr_size = {hdr_size[23:0], hb};
        frame_cnt++;
        if (frame_cnt < lse_pkg::SIZE_BYTES) return;
        frame_cnt = '0;
        if (hdr_size == '0) begin
          fr_phase = FR_DONE;
          queue_result(8'h00, 1'b0, 1'b1, lse_pkg::ST_ZERO_LEN);
        end else begin
          fr_phase = FR_BODY;
        end
      end
      FR_BODY: begin
        frame_cnt++;
        if (frame_cnt == hdr_size) begin
          frame_cnt = '0;
          fr_phase  = FR_EXT;
          queue_result(hb, 1'b0, 1'b1, lse_pkg::ST_OK);
        end else begin
          queue_result(hb, 1'b0, 1'b0, lse_pkg::ST_OK);
        end
      end
      default: begin
        if (frame_cnt == '0 && hb != lse_pkg::CHAR_DOT) begin
          fr_phase = FR_DONE;
          queue_result(hb, 1'b1, 1'b1, lse_pkg::ST_NO_DOT);
        end else if (hb == lse_pkg::CHAR_NUL) begin
          fr_phase = FR_DONE;
          queue_result(hb, 1'b1, 1'b1, lse_pkg::ST_OK);
        end else if (frame_cnt + 1 >= lse_pkg::MAX_EXT_LEN) begin
          fr_phase = FR_DONE;
          queue_result(hb, 1'b1, 1'b1, lse_pkg::ST_TOO_LONG);
        end else begin
          frame_cnt++;
          queue_result(hb, 1'b1, 1'b0, lse_pkg::ST_OK);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------- driver
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin : driver_blk
    cover_t item;
    if (!rst_ni) begin
      tx_valid <= 1'b0;
    end else begin
      if (tx_valid && s_axis_tready) recover_hidden(tx_data, tx_user[0]);
      if (!tx_valid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          tx_valid <= 1'b0;
        end else if (cover_q.size() != 0) begin
          item = cover_q.pop_front();
          tx_valid <= 1'b1;
          tx_data  <= item.data;
          tx_user  <= item.start;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            // a third of bursts run straight into the next one
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          tx_valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------- receiver
  int unsigned rx_taken   = 0;
  int unsigned hold_left  = 0;
  logic        hold_done  = 1'b0;
  int unsigned style      = 0;
  int unsigned style_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid && rx_ready) rx_taken++;
      if (hold_left != 0) begin
        hold_left--;
        rx_ready <= 1'b0;
      end else if (!hold_done && rx_taken >= HOLD_AFTER) begin
        // long back-pressure so the core fills and stalls its input
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        rx_ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 2);
          style_left = $urandom_range(8, 80);
        end else begin
          style_left--;
        end
        case (style)
          0:       rx_ready <= 1'b1;
          1:       rx_ready <= 1'($urandom_range(0, 1));
          default: rx_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------- monitor
  always @(posedge clk_i) begin : monitor_blk
    lse_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && rx_ready) begin
      if (recovered_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word data=%h user=%h last=%b",
                                  m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want = recovered_q.pop_front();
        if (m_axis_tdata[7:0] !== want.out_byte)
          report_mismatch($sformatf("out_byte %h, want %h", m_axis_tdata[7:0], want.out_byte));
        if (m_axis_tdata[39:8] !== want.payload_size)
          report_mismatch($sformatf("payload_size %h, want %h", m_axis_tdata[39:8],
                                    want.payload_size));
        if (m_axis_tuser[0] !== want.is_extension)
          report_mismatch($sformatf("is_extension %b, want %b", m_axis_tuser[0],
                                    want.is_extension));
        if (m_axis_tuser[2:1] !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", m_axis_tuser[2:1], want.status));
        if (m_axis_tlast !== want.last_of_part)
          report_mismatch($sformatf("last %b, want %b", m_axis_tlast, want.last_of_part));
      end
    end
  end

  // ------------------------------------------------------------- generator
  task automatic queue_cover(input logic [7:0] d, input logic s);
    cover_t c;
    c.data  = d;
    c.start = s;
    cover_q.push_back(c);
  endtask

  task automatic add_cover(input logic [7:0] d);
    cover_t c;
    c.data        = d;
    c.start       = start_pending;
    start_pending = 1'b0;
    frame_q.push_back(c);
  endtask

  // spread one hidden byte over cover words for the current mode
  task automatic hide_byte(input logic [7:0] hb);
    logic [7:0] c;
    if (mode_reg == lse_pkg::MODE_LSB4) begin
      c = 8'($urandom);
      add_cover({c[7:4], hb[7:4]});
      c = 8'($urandom);
      add_cover({c[7:4], hb[3:0]});
    end else begin
      for (int i = 7; i >= 0; i--) begin
        c = 8'($urandom);
        c[0] = (mode_reg == lse_pkg::MODE_LSBI) ? hb[i] ^ gen_key[c[2:1]] : hb[i];
        add_cover(c);
      end
    end
  endtask

  task automatic build_frame(input int kind, input logic cont);
    logic [63:0] size;
    int unsigned body_len;
    int unsigned ext_len;
    int unsigned keep;
    logic [7:0]  c;
    frame_q.delete();
    start_pending = !cont;
    if (mode_reg == lse_pkg::MODE_LSBI && !cont) begin
      gen_key = 4'($urandom);
      for (int i = 0; i < lse_pkg::FLAG_BYTES; i++) begin
        c = 8'($urandom);
        c[0] = gen_key[i];
        add_cover(c);
      end
    end

    if (kind == FK_ZERO)
      size = '0;
    else if (kind == FK_CUT && $urandom_range(0, 1) == 0)
      size = 64'($urandom);
    else if (mode_reg == lse_pkg::MODE_LSB4)
      size = 64'($urandom_range(1, 24));
    else
      size = 64'($urandom_range(1, 5));
    for (int i = int'(lse_pkg::SIZE_BYTES) - 1; i >= 0; i--) hide_byte(size[8*i +: 8]);

    body_len = (size > 64'd40) ? 40 : 32'(size);
    for (int i = 0; i < body_len; i++) hide_byte(8'($urandom));

    if (size != 0) begin
      case (kind)
        FK_NODOT: begin
          // a NUL in place of the dot is an error too
          if ($urandom_range(0, 3) == 0) begin
            hide_byte(lse_pkg::CHAR_NUL);
          end else begin
            do c = 8'($urandom); while (c == lse_pkg::CHAR_DOT);
            hide_byte(c);
          end
        end
        FK_LONG: begin
          hide_byte(lse_pkg::CHAR_DOT);
          for (int i = 1; i < lse_pkg::MAX_EXT_LEN; i++) hide_byte(8'($urandom_range(1, 255)));
        end
        default: begin
          ext_len = $urandom_range(0, lse_pkg::MAX_EXT_LEN - 2);
          hide_byte(lse_pkg::CHAR_DOT);
          for (int i = 0; i < ext_len; i++) hide_byte(8'($urandom_range(1, 255)));
          hide_byte(lse_pkg::CHAR_NUL);
        end
      endcase
    end

    if (kind == FK_CUT) begin
      keep = $urandom_range(1, frame_q.size());
      while (frame_q.size() > keep) void'(frame_q.pop_back());
    end
    foreach (frame_q[i]) cover_q.push_back(frame_q[i]);
    items_sent += frame_q.size();

    // trailing words land in the idle state; after a cut frame they may restart it
    repeat ($urandom_range(0, 4))
      queue_cover(8'($urandom), (kind == FK_CUT) ? ($urandom_range(0, 7) == 0) : 1'b0);
  endtask

  // wait for the core to go quiet; leftovers are failures
  task automatic drain();
    int unsigned waited;
    waited = 0;
    while ((cover_q.size() != 0 || tx_valid || recovered_q.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (recovered_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected words never arrived", recovered_q.size()));
      recovered_q.delete();
    end
  endtask

  task automatic write_mode(input logic [1:0] m);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid <= 1'b0;
    mode_reg = m;
  endtask

  // directed frames, LSB4: zero size header, then size 1 with a NUL for the dot
  localparam logic [63:0] ZERO_HDR  = 64'h00F0_50A0_00F0_30C0;
  localparam logic [95:0] NUL_FRAME = 96'h00F0_00F0_00F0_00F1_0FFF_F000;

  initial begin : stimulus_blk
    int          kind;
    logic [1:0]  m;
    logic        cont;
    int unsigned phase_idx;
    int unsigned n_frames;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_mode(lse_pkg::MODE_LSB4);
    for (int i = 7; i >= 0; i--) queue_cover(ZERO_HDR[8*i +: 8], i == 7);
    queue_cover(8'hFF, 1'b0);  // idle, ignored
    queue_cover(8'h0F, 1'b0);
    for (int i = 11; i >= 0; i--) queue_cover(NUL_FRAME[8*i +: 8], i == 11);
    drain();

    // first phases walk mode three, LSBI, LSB1, LSB4; then random
    phase_idx = 0;
    while (items_sent < ITEMS_TARGET) begin
      case (phase_idx)
        0:       m = 2'd3;
        1:       m = lse_pkg::MODE_LSBI;
        2:       m = lse_pkg::MODE_LSB1;
        3:       m = lse_pkg::MODE_LSB4;
        default: m = 2'($urandom_range(0, 3));
      endcase
      // sender holds off here until every word is back
      drain();
      write_mode(m);
      n_frames = $urandom_range(1, 3);
      for (int f = 0; f < n_frames; f++) begin
        // picking up a cut frame in the new mode mixes modes within one byte
        cont = (f == 0) && (phase_idx == 1 || $urandom_range(0, 4) == 0);
        if (phase_idx == 0 && f == n_frames - 1) begin
          kind = FK_CUT;
        end else begin
          case ($urandom_range(0, 9))
            0:       kind = FK_ZERO;
            1:       kind = FK_NODOT;
            2:       kind = FK_LONG;
            3, 4:    kind = FK_CUT;
            default: kind = FK_GOOD;
          endcase
        end
        build_frame(kind, cont);
      end
      phase_idx++;
    end

    drain();
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- lsb_stego_extractor_core.f -----
rtl/core/lse_pkg.sv
rtl/core/lse_bit_gather.sv
rtl/core/lse_deframer.sv
rtl/core/lsb_stego_extractor_core.sv
rtl/core/lse_checker.sv
verif/tb.sv
